FILE: hw/rtl/rhm_pkg.sv
`timescale 1ns / 1ps
// Shared types and sizes for the row horizontal mirror.
// No dependencies; every other file depends on this package.
package rhm_pkg;

	localparam int MAX_WIDTH   = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WID_W       = $clog2(MAX_WIDTH + 1);
	localparam int CFG_W       = 7;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [WID_W-1:0]       width_t;
	typedef logic [COL_W-1:0]       col_t;
	typedef logic [CFG_W-1:0]       cfg_width_t;

	typedef struct packed {
		sample_t red;
		sample_t green;
		sample_t blue;
	} pix_t;

	// write port from the front end into the row store
	typedef struct packed {
		logic en;
		col_t addr;
		pix_t data;
	} st_wr_t;

endpackage

FILE: hw/rtl/rhm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: configuration, pixel in, pixel out.
// Depends on rhm_pkg.
interface rhm_cfg_if;
	logic                valid;
	logic                ready;
	rhm_pkg::cfg_width_t row_width;
	modport source (output valid, output row_width, input ready);
	modport sink   (input valid, input row_width, output ready);
endinterface

interface rhm_pix_in_if;
	logic             valid;
	logic             ready;
	rhm_pkg::sample_t red_in;
	rhm_pkg::sample_t green_in;
	rhm_pkg::sample_t blue_in;
	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rhm_pix_out_if;
	logic             valid;
	logic             ready;
	rhm_pkg::sample_t red_out;
	rhm_pkg::sample_t green_out;
	rhm_pkg::sample_t blue_out;
	logic             row_end;
	modport source (output valid, output red_out, output green_out, output blue_out,
		output row_end, input ready);
	modport sink   (input valid, input red_out, input green_out, input blue_out,
		input row_end, output ready);
endinterface

FILE: hw/rtl/row_horizontal_mirror.sv
`timescale 1ns / 1ps
// Row horizontal mirror: flips an RGB image left to right, one row at a time.
// Depends on rhm_pkg, rhm_if, rhm_front, rhm_fifo, rhm_back.
//
// Channels: pix_in takes pixels in raster order; pix_out gives each row back
// in reverse column order with row_end set on its last word; cfg writes the
// row width (0 acts as 1, above 64 acts as 64) and is always ready. Write it
// only while the block is idle.
// Timing: a row of W pixels is taken at one pixel per cycle, while input is
// not held off, into a 64-entry row store. After the row's last pixel its
// width passes through the row command queue to the back end, which reads
// the store one entry per cycle while pix_out is not stalled; each word goes
// through the read register, then the output word register. Input is held
// off from the completing pixel until the row's last entry has been read.
// Reset: clears the column count, the queue and the output valid; the width
// register returns to 64. Store contents are left as they were.
// Stall: when pix_out.ready is low the output word and one read word wait
// in registers; reading stops and pixel input stays held until the row drains.
module row_horizontal_mirror (
	input  logic          clk,
	input  logic          arst_n,
	rhm_cfg_if.sink       cfg,
	rhm_pix_in_if.sink    pix_in,
	rhm_pix_out_if.source pix_out
);
	import rhm_pkg::*;

	cfg_width_t row_width_q;
	width_t     eff_width;
	st_wr_t     wr;
	logic       push;
	width_t     push_width;
	logic       q_full;
	logic       q_empty;
	width_t     q_data;
	logic       pop;
	logic       done;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= cfg_width_t'(MAX_WIDTH);
		end else if (cfg.valid) begin
			row_width_q <= cfg.row_width;
		end
	end

	always_comb begin
		if (row_width_q == '0) begin
			eff_width = width_t'(1);
		end else if (row_width_q > cfg_width_t'(MAX_WIDTH)) begin
			eff_width = width_t'(MAX_WIDTH);
		end else begin
			eff_width = width_t'(row_width_q);
		end
	end

	rhm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in),
		.eff_width  (eff_width),
		.q_full     (q_full),
		.rel        (done),
		.wr         (wr),
		.push       (push),
		.push_width (push_width)
	);

	rhm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_width),
		.pop       (pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	rhm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.q_empty (q_empty),
		.q_data  (q_data),
		.pop     (pop),
		.done    (done),
		.pix_out (pix_out)
	);

endmodule

FILE: hw/rtl/rhm_front.sv
`timescale 1ns / 1ps
// Front end: accepts pixels, counts columns, writes the row store and
// posts a row command when a row completes. Depends on rhm_pkg, rhm_if.
module rhm_front (
	input  logic              clk,
	input  logic              arst_n,
	rhm_pix_in_if.sink        pix_in,
	input  rhm_pkg::width_t   eff_width,
	input  logic              q_full,
	input  logic              rel,
	output rhm_pkg::st_wr_t   wr,
	output logic              push,
	output rhm_pkg::width_t   push_width
);
	import rhm_pkg::*;

	col_t   col_q;
	logic   hold_q;
	logic   acc;
	logic   last;
	width_t nxt;

	assign pix_in.ready = !hold_q && !q_full;
	assign acc          = pix_in.valid && pix_in.ready;
	assign nxt          = {1'b0, col_q} + width_t'(1);
	// count may pass a width lowered mid row, so compare with >=
	assign last         = nxt >= eff_width;

	assign wr.en         = acc;
	assign wr.addr       = col_q;
	assign wr.data.red   = pix_in.red_in;
	assign wr.data.green = pix_in.green_in;
	assign wr.data.blue  = pix_in.blue_in;

	assign push       = acc && last;
	assign push_width = eff_width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			hold_q <= 1'b0;
		end else begin
			if (acc) begin
				col_q <= last ? '0 : nxt[COL_W-1:0];
			end
			// hold off new pixels until the back end has read the whole row
			if (push) begin
				hold_q <= 1'b1;
			end else if (rel) begin
				hold_q <= 1'b0;
			end
		end
	end

	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> hold_q) else $error("row completed without holding input");
	a_col_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> col_q == '0) else $error("column count not cleared at row end");
	a_col_steps: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !last |=> col_q == $past(col_q) + col_t'(1))
		else $error("column count did not advance");

endmodule

FILE: hw/rtl/rhm_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of row commands (row widths) between front and back end.
// Depends on rhm_pkg.
module rhm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rhm_pkg::width_t push_data,
	input  logic            pop,
	output rhm_pkg::width_t pop_data,
	output logic            full,
	output logic            empty
);
	import rhm_pkg::*;

	width_t     slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign pop_data = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= !wp_q;
			end
			if (pop && !empty) begin
				rp_q <= !rp_q;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/rhm_back.sv
`timescale 1ns / 1ps
// Back end: holds the row store, reads a completed row from the top column
// down and drives the output word register. Depends on rhm_pkg, rhm_if.
module rhm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rhm_pkg::st_wr_t wr,
	input  logic            q_empty,
	input  rhm_pkg::width_t q_data,
	output logic            pop,
	output logic            done,
	rhm_pix_out_if.source   pix_out
);
	import rhm_pkg::*;

	pix_t   mem [MAX_WIDTH];
	width_t cnt_q;
	col_t   rd_addr;
	logic   issue;
	logic   mv;
	logic   rd_valid_s1;
	pix_t   rd_data_s1;
	logic   row_end_s1;
	logic   out_valid_q;
	pix_t   out_q;
	logic   row_end_q;

	assign rd_addr = col_t'(cnt_q - width_t'(1));
	assign pop     = (cnt_q == '0) && !q_empty;
	assign mv      = rd_valid_s1 && (!out_valid_q || pix_out.ready);
	assign issue   = (cnt_q != '0) && (!rd_valid_s1 || mv);
	// last read of the row; the store may be refilled from the next cycle
	assign done    = issue && (cnt_q == width_t'(1));

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
			row_end_s1 <= rd_addr == '0;
		end
		if (mv) begin
			out_q     <= rd_data_s1;
			row_end_q <= row_end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cnt_q <= q_data;
			end else if (issue) begin
				cnt_q <= cnt_q - width_t'(1);
			end
			if (issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (mv) begin
				rd_valid_s1 <= 1'b0;
			end
			if (mv) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.red_out   = out_q.red;
	assign pix_out.green_out = out_q.green;
	assign pix_out.blue_out  = out_q.blue;
	assign pix_out.row_end   = row_end_q;

	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 && !mv |=> $stable(rd_data_s1) && $stable(row_end_s1))
		else $error("stalled read word changed");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> cnt_q == '0) else $error("row read finished with reads left");
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> cnt_q != '0) else $error("row command loaded zero width");

endmodule
